>>> rtl/core/rpp_pkg.sv
// ----------------------------------------------------------------------------
// Replication packet parser package
// Shared types, codes and helper function of the packet parser.
// ----------------------------------------------------------------------------
package rpp_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'b1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [31:0] MAGIC_RESET   = 32'h4158_5250;
    localparam logic [15:0] VERSION_RESET = 16'd1;

    localparam logic [3:0] HDR_LEN = 4'd8;

    // Flags byte
    localparam logic [7:0] FLAG_ALLOWED = 8'h87;
    localparam logic [7:0] FLAG_REMOVE  = 8'h80;
    localparam logic [7:0] FLAG_GROUPS  = 8'h07;

    // Result kinds
    localparam logic [2:0] KIND_ENTRY   = 3'd0;
    localparam logic [2:0] KIND_POS     = 3'd1;
    localparam logic [2:0] KIND_ROT     = 3'd2;
    localparam logic [2:0] KIND_SCALE   = 3'd3;
    localparam logic [2:0] KIND_VERDICT = 3'd4;

    // Verdict codes
    localparam logic [3:0] V_OK        = 4'd0;
    localparam logic [3:0] V_SHORT     = 4'd1;
    localparam logic [3:0] V_MAGIC     = 4'd2;
    localparam logic [3:0] V_VERSION   = 4'd3;
    localparam logic [3:0] V_ID        = 4'd4;
    localparam logic [3:0] V_FLAGS     = 4'd5;
    localparam logic [3:0] V_NONFINITE = 4'd6;
    localparam logic [3:0] V_TRUNC     = 4'd7;
    localparam logic [3:0] V_TRAILING  = 4'd8;

    // Entry phase: id bytes, flags byte, then one phase per float word
    typedef enum logic [3:0] {
        PH_ID      = 4'd0,
        PH_FLAGS   = 4'd1,
        PH_POS_X   = 4'd2,
        PH_POS_Y   = 4'd3,
        PH_POS_Z   = 4'd4,
        PH_ROT_X   = 4'd5,
        PH_ROT_Y   = 4'd6,
        PH_ROT_Z   = 4'd7,
        PH_ROT_W   = 4'd8,
        PH_SCALE_X = 4'd9,
        PH_SCALE_Y = 4'd10,
        PH_SCALE_Z = 4'd11
    } t_phase;

    typedef struct packed {
        logic [2:0]  out_kind;
        logic [15:0] entry_index;
        logic [1:0]  component;
        logic [31:0] entity_id;
        logic [7:0]  entry_flags;
        logic [31:0] word_value;
        logic [3:0]  verdict;
        logic        end_of_packet;
    } t_result;

    // Results of one accepted item; slot 0 always fills first
    typedef struct packed {
        logic    valid0;
        logic    valid1;
        t_result res0;
        t_result res1;
    } t_push;

    // First word phase of the groups from grp on that the flags select; PH_ID if none
    function automatic t_phase first_word_from(input logic [1:0] grp, input logic [7:0] flags);
        t_phase ph;
        ph = PH_ID;
        if (grp <= 2'd2 && flags[2]) ph = PH_SCALE_X;
        if (grp <= 2'd1 && flags[1]) ph = PH_ROT_X;
        if (grp == 2'd0 && flags[0]) ph = PH_POS_X;
        return ph;
    endfunction

endpackage

>>> rtl/core/rpp_in_if.sv
// ----------------------------------------------------------------------------
// Packet byte channel
// Valid/ready channel that carries one packet byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface rpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source(output valid, output data_byte, output last_byte, input ready);
    modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

>>> rtl/core/rpp_out_if.sv
// ----------------------------------------------------------------------------
// Parse result channel
// Valid/ready channel that carries entry headers, float words and verdicts.
// ----------------------------------------------------------------------------
interface rpp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_kind;
    logic [15:0] entry_index;
    logic [1:0]  component;
    logic [31:0] entity_id;
    logic [7:0]  entry_flags;
    logic [31:0] word_value;
    logic [3:0]  verdict;
    logic        end_of_packet;

    modport source(output valid, output out_kind, output entry_index, output component,
                   output entity_id, output entry_flags, output word_value,
                   output verdict, output end_of_packet, input ready);
    modport sink(input valid, input out_kind, input entry_index, input component,
                 input entity_id, input entry_flags, input word_value,
                 input verdict, input end_of_packet, output ready);
endinterface

>>> rtl/core/rpp_parser.sv
// ----------------------------------------------------------------------------
// Packet parser core
// Per-byte header, entry and float checks; emits up to two results per item.
// ----------------------------------------------------------------------------
module rpp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_data,
    input  logic                 i_last,
    input  logic [31:0]          i_magic,
    input  logic [15:0]          i_version,
    output rpp_pkg::t_push       o_push
);

    logic [3:0]      r_hdr_pos, n_hdr_pos;
    logic [31:0]     r_shift, n_shift;
    logic [15:0]     r_declared, n_declared;
    logic [15:0]     r_done, n_done;
    rpp_pkg::t_phase r_phase, n_phase;
    logic [1:0]      r_wcnt, n_wcnt;
    logic [7:0]      r_flags, n_flags;
    logic [31:0]     r_id, n_id;
    logic [3:0]      r_err, n_err;

    logic [31:0]     sh_new;
    logic            flags_bad;
    logic [1:0]      grp;
    logic [1:0]      comp;
    logic            grp_end;
    rpp_pkg::t_phase nxt_phase;
    logic [3:0]      vcode;
    rpp_pkg::t_result res_verdict;

    assign sh_new = {r_shift[23:0], i_data};

    assign flags_bad = (|(i_data & ~rpp_pkg::FLAG_ALLOWED))
                    || (i_data[7] && i_data != rpp_pkg::FLAG_REMOVE)
                    || (!i_data[7] && (i_data & rpp_pkg::FLAG_GROUPS) == 8'd0);

    // Decode float group and axis from the phase
    always_comb begin
        if (r_phase < rpp_pkg::PH_ROT_X) begin
            grp     = 2'd0;
            comp    = 2'(r_phase - rpp_pkg::PH_POS_X);
            grp_end = (r_phase == rpp_pkg::PH_POS_Z);
        end else if (r_phase < rpp_pkg::PH_SCALE_X) begin
            grp     = 2'd1;
            comp    = 2'(r_phase - rpp_pkg::PH_ROT_X);
            grp_end = (r_phase == rpp_pkg::PH_ROT_W);
        end else begin
            grp     = 2'd2;
            comp    = 2'(r_phase - rpp_pkg::PH_SCALE_X);
            grp_end = (r_phase == rpp_pkg::PH_SCALE_Z);
        end
        nxt_phase = rpp_pkg::first_word_from(grp + 2'd1, r_flags);
    end

    always_comb begin
        n_hdr_pos  = r_hdr_pos;
        n_shift    = r_shift;
        n_declared = r_declared;
        n_done     = r_done;
        n_phase    = r_phase;
        n_wcnt     = r_wcnt;
        n_flags    = r_flags;
        n_id       = r_id;
        n_err      = r_err;
        o_push     = '0;
        vcode      = rpp_pkg::V_OK;
        res_verdict = '0;

        if (i_fire) begin
            if (r_hdr_pos < rpp_pkg::HDR_LEN) begin
                n_shift   = sh_new;
                n_hdr_pos = r_hdr_pos + 4'd1;
                if (r_hdr_pos == 4'd3 && sh_new != i_magic) begin
                    if (r_err == rpp_pkg::V_OK) n_err = rpp_pkg::V_MAGIC;
                end else if (r_hdr_pos == 4'd5 && sh_new[15:0] != i_version) begin
                    if (r_err == rpp_pkg::V_OK) n_err = rpp_pkg::V_VERSION;
                end else if (r_hdr_pos == 4'd7) begin
                    n_declared = sh_new[15:0];
                end
            end else if (r_err != rpp_pkg::V_OK) begin
                // drop bytes until the end of the packet
            end else if (r_done >= r_declared) begin
                n_err = rpp_pkg::V_TRAILING;
            end else if (r_phase == rpp_pkg::PH_ID) begin
                n_shift = sh_new;
                n_wcnt  = r_wcnt + 2'd1;
                if (r_wcnt == 2'd3) begin
                    n_id    = sh_new;
                    n_phase = rpp_pkg::PH_FLAGS;
                    // an id finished on the last byte reads as truncation instead
                    if (!i_last && sh_new == 32'd0) n_err = rpp_pkg::V_ID;
                end
            end else if (r_phase == rpp_pkg::PH_FLAGS) begin
                n_flags = i_data;
                if (flags_bad) begin
                    n_err = rpp_pkg::V_FLAGS;
                end else begin
                    o_push.valid0           = 1'b1;
                    o_push.res0.out_kind    = rpp_pkg::KIND_ENTRY;
                    o_push.res0.entry_index = r_done;
                    o_push.res0.entity_id   = r_id;
                    o_push.res0.entry_flags = i_data;
                    if (i_data == rpp_pkg::FLAG_REMOVE) begin
                        n_done  = r_done + 16'd1;
                        n_phase = rpp_pkg::PH_ID;
                    end else begin
                        n_phase = rpp_pkg::first_word_from(2'd0, i_data);
                    end
                end
            end else begin
                n_shift = sh_new;
                n_wcnt  = r_wcnt + 2'd1;
                if (r_wcnt == 2'd3) begin
                    if (sh_new[30:23] == 8'hFF) begin
                        n_err = rpp_pkg::V_NONFINITE;
                    end else begin
                        o_push.valid0           = 1'b1;
                        o_push.res0.out_kind    = 3'({1'b0, grp} + 3'd1);
                        o_push.res0.entry_index = r_done;
                        o_push.res0.component   = comp;
                        o_push.res0.entity_id   = r_id;
                        o_push.res0.entry_flags = r_flags;
                        o_push.res0.word_value  = sh_new;
                        if (!grp_end) begin
                            n_phase = rpp_pkg::t_phase'(r_phase + 4'd1);
                        end else begin
                            n_phase = nxt_phase;
                            if (nxt_phase == rpp_pkg::PH_ID) n_done = r_done + 16'd1;
                        end
                    end
                end
            end

            if (i_last) begin
                if (n_hdr_pos < rpp_pkg::HDR_LEN)      vcode = rpp_pkg::V_SHORT;
                else if (n_err != rpp_pkg::V_OK)       vcode = n_err;
                else if (n_done >= n_declared)         vcode = rpp_pkg::V_OK;
                else                                   vcode = rpp_pkg::V_TRUNC;
                res_verdict.out_kind      = rpp_pkg::KIND_VERDICT;
                res_verdict.entry_index   = n_done;
                res_verdict.verdict       = vcode;
                res_verdict.end_of_packet = 1'b1;
                if (o_push.valid0) begin
                    o_push.valid1 = 1'b1;
                    o_push.res1   = res_verdict;
                end else begin
                    o_push.valid0 = 1'b1;
                    o_push.res0   = res_verdict;
                end
                // start the next packet from a clean state
                n_hdr_pos  = '0;
                n_shift    = '0;
                n_declared = '0;
                n_done     = '0;
                n_phase    = rpp_pkg::PH_ID;
                n_wcnt     = '0;
                n_flags    = '0;
                n_id       = '0;
                n_err      = rpp_pkg::V_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_pos  <= '0;
            r_shift    <= '0;
            r_declared <= '0;
            r_done     <= '0;
            r_phase    <= rpp_pkg::PH_ID;
            r_wcnt     <= '0;
            r_flags    <= '0;
            r_id       <= '0;
            r_err      <= rpp_pkg::V_OK;
        end else begin
            r_hdr_pos  <= n_hdr_pos;
            r_shift    <= n_shift;
            r_declared <= n_declared;
            r_done     <= n_done;
            r_phase    <= n_phase;
            r_wcnt     <= n_wcnt;
            r_flags    <= n_flags;
            r_id       <= n_id;
            r_err      <= n_err;
        end
    end

    a_hdr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hdr_pos <= rpp_pkg::HDR_LEN)
        else $error("header position beyond header length");

    a_entry_after_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != rpp_pkg::PH_ID || r_wcnt != 2'd0) |-> r_hdr_pos == rpp_pkg::HDR_LEN)
        else $error("entry parsing started inside the header");

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != rpp_pkg::V_OK && !(i_fire && i_last)) |=> r_err == $past(r_err))
        else $error("latched error changed before end of packet");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push.valid1 |-> (o_push.valid0 && o_push.res1.end_of_packet))
        else $error("second result slot used without verdict in order");

endmodule

>>> rtl/core/rpp_out_fifo.sv
// ----------------------------------------------------------------------------
// Result queue
// Small register queue that takes up to two results a cycle and drives the
// result channel one item a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
module rpp_out_fifo #(
    parameter int unsigned P_DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rpp_pkg::t_push   i_push,
    output logic             o_room,
    rpp_out_if.source        o_out_chan
);

    localparam int unsigned PTR_W = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(P_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(P_DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX = CNT_W'(P_DEPTH - 2);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(P_DEPTH);

    rpp_pkg::t_result mem [P_DEPTH];

    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;
    logic [PTR_W-1:0] wr_next;
    logic             pop;
    rpp_pkg::t_result head;

    assign wr_next = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
    assign pop     = o_out_chan.valid && o_out_chan.ready;
    assign o_room  = (r_count <= ROOM_MAX);

    always_comb begin
        n_wr = r_wr;
        if (i_push.valid1) n_wr = (wr_next == LAST_PTR) ? '0 : wr_next + PTR_W'(1);
        else if (i_push.valid0) n_wr = wr_next;
        n_rd = r_rd;
        if (pop) n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        n_count = r_count + CNT_W'(i_push.valid0) + CNT_W'(i_push.valid1) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid0) mem[r_wr] <= i_push.res0;
        if (i_push.valid1) mem[wr_next] <= i_push.res1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    assign head                     = mem[r_rd];
    assign o_out_chan.valid         = (r_count != '0);
    assign o_out_chan.out_kind      = head.out_kind;
    assign o_out_chan.entry_index   = head.entry_index;
    assign o_out_chan.component     = head.component;
    assign o_out_chan.entity_id     = head.entity_id;
    assign o_out_chan.entry_flags   = head.entry_flags;
    assign o_out_chan.word_value    = head.word_value;
    assign o_out_chan.verdict       = head.verdict;
    assign o_out_chan.end_of_packet = head.end_of_packet;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid0 |-> o_room)
        else $error("results pushed without room for two");

endmodule

>>> rtl/core/replication_packet_parser.sv
// ----------------------------------------------------------------------------
// Replication packet parser
// Checks a byte stream packet header and entries and emits parse results.
// ----------------------------------------------------------------------------
// Usage:
//   i_in_chan carries one packet byte per item with last_byte on the final
//   byte. o_out_chan returns entry headers (kind 0), position, rotation and
//   scale words (kinds 1..3) as they are parsed, and on the last byte a
//   verdict (kind 4, end_of_packet = 1). The consumer commits or drops the
//   packet's results according to the verdict.
//   Each byte is checked in the cycle it is accepted; its results (at most
//   two) are written to a registered result queue that drives o_out_chan.
//   A new byte is taken every cycle while the queue has room for two
//   results, so the parser runs at one byte per cycle when the receiver takes
//   one result per cycle. When the receiver stalls, the queue fills and
//   i_in_chan.ready drops until it drains.
//   Reset empties the queue, clears the packet state and loads the magic and
//   version registers with their defaults. Write the registers through the
//   i_cfg_* port only while the parser is idle.
// ----------------------------------------------------------------------------
module replication_packet_parser #(
    parameter int unsigned P_FIFO_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rpp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rpp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    rpp_in_if.sink                            i_in_chan,
    rpp_out_if.source                         o_out_chan
);

    logic [31:0]    r_magic;
    logic [15:0]    r_version;
    logic           room;
    logic           fire;
    rpp_pkg::t_push push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic   <= rpp_pkg::MAGIC_RESET;
            r_version <= rpp_pkg::VERSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpp_pkg::CFG_MAGIC:   r_magic   <= i_cfg_data[31:0];
                rpp_pkg::CFG_VERSION: r_version <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign i_in_chan.ready = room;
    assign fire            = i_in_chan.valid && room;

    rpp_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_data    (i_in_chan.data_byte),
        .i_last    (i_in_chan.last_byte),
        .i_magic   (r_magic),
        .i_version (r_version),
        .o_push    (push)
    );

    rpp_out_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_room     (room),
        .o_out_chan (o_out_chan)
    );

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Replication packet parser testbench
// Sends packets one byte per item, well-formed and broken, under several
// magic and version settings, and checks every entry header, float word and
// verdict in order against a shadow copy of the parser state.
// ----------------------------------------------------------------------------
module tb_top;

    typedef logic [7:0] t_bytes[$];

    typedef enum int {
        F_NONE,
        F_CUT,
        F_CORRUPT,
        F_TRAILING,
        F_ZERO_ID,
        F_BAD_FLAGS,
        F_NONFINITE,
        F_NOISE,
        F_HEADER,
        F_OVERCOUNT
    } t_fault;

    localparam logic [7:0] FL_POS      = 8'h01;
    localparam logic [7:0] FL_ROT      = 8'h02;
    localparam logic [7:0] FL_SCALE    = 8'h04;
    localparam logic [7:0] EXP_SPECIAL = 8'hFF;
    localparam int GAP_PCT         = 7;
    localparam int SETTLE_CYCLES   = 8;
    localparam int BYTES_PER_SETUP = 20;
    localparam int BYTES_NO_IDLE   = 100;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [rpp_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [rpp_pkg::CFG_DATA_W-1:0] i_cfg_data;

    rpp_in_if  in_chan();
    rpp_out_if out_chan();

    replication_packet_parser u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_chan   (in_chan),
        .o_out_chan  (out_chan)
    );

    // Shadow of the parser registers and packet state
    logic [31:0]     cfg_magic;
    logic [15:0]     cfg_version;
    logic [3:0]      hdr_count;
    logic [31:0]     shift_word;
    logic [15:0]     entries_declared;
    logic [15:0]     entries_done;
    rpp_pkg::t_phase entry_phase;
    logic [1:0]      word_bytes;
    logic [7:0]      cur_flags;
    logic [31:0]     cur_id;
    logic [3:0]      packet_error;

    rpp_pkg::t_result pending_results[$];
    int      error_count    = 0;
    int      src_gap_pct    = GAP_PCT;
    int      sink_stall_pct = GAP_PCT;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        out_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Shadow parser
    // ------------------------------------------------------------------------
    function automatic void clear_packet();
        hdr_count        = 4'd0;
        shift_word       = 32'd0;
        entries_declared = 16'd0;
        entries_done     = 16'd0;
        entry_phase      = rpp_pkg::PH_ID;
        word_bytes       = 2'd0;
        cur_flags        = 8'd0;
        cur_id           = 32'd0;
        packet_error     = rpp_pkg::V_OK;
    endfunction

    function automatic void latch_error(logic [3:0] code);
        if (packet_error == rpp_pkg::V_OK) begin
            packet_error = code;
        end
    endfunction

    function automatic bit flags_valid(logic [7:0] f);
        if ((f & ~rpp_pkg::FLAG_ALLOWED) != 8'd0) return 1'b0;
        if ((f & rpp_pkg::FLAG_REMOVE) != 8'd0) return f == rpp_pkg::FLAG_REMOVE;
        return (f & rpp_pkg::FLAG_GROUPS) != 8'd0;
    endfunction

    // First word phase among the groups from grp on; PH_ID when none is left
    function automatic rpp_pkg::t_phase group_entry(int grp, logic [7:0] f);
        if (grp <= 0 && (f & FL_POS) != 8'd0) return rpp_pkg::PH_POS_X;
        if (grp <= 1 && (f & FL_ROT) != 8'd0) return rpp_pkg::PH_ROT_X;
        if (grp <= 2 && (f & FL_SCALE) != 8'd0) return rpp_pkg::PH_SCALE_X;
        return rpp_pkg::PH_ID;
    endfunction

    function automatic void finish_entry();
        entries_done++;
        entry_phase = rpp_pkg::PH_ID;
    endfunction

    function automatic void expect_result(logic [2:0] kind, logic [1:0] comp,
                                          logic [31:0] id, logic [7:0] flags,
                                          logic [31:0] word, logic [3:0] verdict,
                                          logic eop);
        rpp_pkg::t_result r;
        r.out_kind      = kind;
        r.entry_index   = entries_done;
        r.component     = comp;
        r.entity_id     = id;
        r.entry_flags   = flags;
        r.word_value    = word;
        r.verdict       = verdict;
        r.end_of_packet = eop;
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic void parse_byte(logic [7:0] b, logic last);
        logic [2:0]      kind;
        logic [1:0]      comp;
        rpp_pkg::t_phase group_last;
        int              grp;
        logic [3:0]      verdict;
        if (hdr_count < rpp_pkg::HDR_LEN) begin
            shift_word = {shift_word[23:0], b};
            hdr_count++;
            if (hdr_count == 4'd4 && shift_word != cfg_magic) begin
                latch_error(rpp_pkg::V_MAGIC);
            end else if (hdr_count == 4'd6 && shift_word[15:0] != cfg_version) begin
                latch_error(rpp_pkg::V_VERSION);
            end else if (hdr_count == rpp_pkg::HDR_LEN) begin
                entries_declared = shift_word[15:0];
            end
        end else if (packet_error != rpp_pkg::V_OK) begin
            // drop everything up to the last byte
        end else if (entries_done >= entries_declared) begin
            latch_error(rpp_pkg::V_TRAILING);
        end else if (entry_phase == rpp_pkg::PH_ID) begin
            shift_word = {shift_word[23:0], b};
            word_bytes++;
            if (word_bytes == 2'd0) begin
                cur_id      = shift_word;
                entry_phase = rpp_pkg::PH_FLAGS;
                // a zero id completed on the last byte reads as truncation
                if (!last && cur_id == 32'd0) latch_error(rpp_pkg::V_ID);
            end
        end else if (entry_phase == rpp_pkg::PH_FLAGS) begin
            cur_flags = b;
            if (!flags_valid(b)) begin
                latch_error(rpp_pkg::V_FLAGS);
            end else begin
                expect_result(rpp_pkg::KIND_ENTRY, 2'd0, cur_id, cur_flags, 32'd0,
                              rpp_pkg::V_OK, 1'b0);
                if (b == rpp_pkg::FLAG_REMOVE) finish_entry();
                else entry_phase = group_entry(0, cur_flags);
            end
        end else begin
            shift_word = {shift_word[23:0], b};
            word_bytes++;
            if (word_bytes == 2'd0) begin
                if (entry_phase < rpp_pkg::PH_ROT_X) begin
                    grp        = 0;
                    kind       = rpp_pkg::KIND_POS;
                    comp       = 2'(entry_phase - rpp_pkg::PH_POS_X);
                    group_last = rpp_pkg::PH_POS_Z;
                end else if (entry_phase < rpp_pkg::PH_SCALE_X) begin
                    grp        = 1;
                    kind       = rpp_pkg::KIND_ROT;
                    comp       = 2'(entry_phase - rpp_pkg::PH_ROT_X);
                    group_last = rpp_pkg::PH_ROT_W;
                end else begin
                    grp        = 2;
                    kind       = rpp_pkg::KIND_SCALE;
                    comp       = 2'(entry_phase - rpp_pkg::PH_SCALE_X);
                    group_last = rpp_pkg::PH_SCALE_Z;
                end
                if (shift_word[30:23] == EXP_SPECIAL) begin
                    latch_error(rpp_pkg::V_NONFINITE);
                end else begin
                    expect_result(kind, comp, cur_id, cur_flags, shift_word,
                                  rpp_pkg::V_OK, 1'b0);
                    if (entry_phase != group_last) begin
                        entry_phase = rpp_pkg::t_phase'(entry_phase + 1);
                    end else begin
                        entry_phase = group_entry(grp + 1, cur_flags);
                        if (entry_phase == rpp_pkg::PH_ID) finish_entry();
                    end
                end
            end
        end
        if (last) begin
            if (hdr_count < rpp_pkg::HDR_LEN) verdict = rpp_pkg::V_SHORT;
            else if (packet_error != rpp_pkg::V_OK) verdict = packet_error;
            else if (entries_done >= entries_declared) verdict = rpp_pkg::V_OK;
            else verdict = rpp_pkg::V_TRUNC;
            expect_result(rpp_pkg::KIND_VERDICT, 2'd0, 32'd0, 8'd0, 32'd0, verdict, 1'b1);
            clear_packet();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            error_count++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        rpp_pkg::t_result want;
        if (i_rst_n && out_chan.valid && out_chan.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $error("result with nothing pending: out_kind %0d verdict %0d",
                       out_chan.out_kind, out_chan.verdict);
            end else begin
                want = pending_results.pop_front();
                check_field("out_kind", 32'(want.out_kind), 32'(out_chan.out_kind));
                check_field("entry_index", 32'(want.entry_index),
                            32'(out_chan.entry_index));
                check_field("component", 32'(want.component), 32'(out_chan.component));
                check_field("entity_id", want.entity_id, out_chan.entity_id);
                check_field("entry_flags", 32'(want.entry_flags),
                            32'(out_chan.entry_flags));
                check_field("word_value", want.word_value, out_chan.word_value);
                check_field("verdict", 32'(want.verdict), 32'(out_chan.verdict));
                check_field("end_of_packet", 32'(want.end_of_packet),
                            32'(out_chan.end_of_packet));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic send_byte(logic [7:0] b, logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            in_chan.valid     <= 1'b0;
            in_chan.data_byte <= 8'($urandom);
            @(posedge i_clk);
        end
        in_chan.valid     <= 1'b1;
        in_chan.data_byte <= b;
        in_chan.last_byte <= last;
        @(posedge i_clk);
        while (!in_chan.ready) @(posedge i_clk);
        parse_byte(b, last);
    endtask

    task automatic send_packet(t_bytes pkt);
        foreach (pkt[i]) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // Drop valid, drain the results, then give the parser time to go quiet
    task automatic settle();
        in_chan.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(logic [31:0] magic, logic [15:0] version);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= rpp_pkg::CFG_MAGIC;
        i_cfg_data  <= magic;
        @(posedge i_clk);
        i_cfg_index <= rpp_pkg::CFG_VERSION;
        i_cfg_data  <= {16'd0, version};
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cfg_magic   = magic;
        cfg_version = version;
    endtask

    // ------------------------------------------------------------------------
    // Packet building
    // ------------------------------------------------------------------------
    function automatic void put_word(ref t_bytes q, input logic [31:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) begin
            q.insert(q.size(), v[8*i +: 8]);
        end
    endfunction

    function automatic void put_header(ref t_bytes q, input logic [31:0] magic,
                                       input logic [15:0] version, input logic [15:0] count);
        put_word(q, magic, 4);
        put_word(q, {16'd0, version}, 2);
        put_word(q, {16'd0, count}, 2);
    endfunction

    function automatic logic [31:0] float_word(bit nonfinite);
        logic [31:0] w;
        w = $urandom;
        if (nonfinite) w[30:23] = EXP_SPECIAL;
        else if (w[30:23] == EXP_SPECIAL) w[30:23] = 8'($urandom_range(254));
        return w;
    endfunction

    // Entry with random float words; word number bad_word is made non-finite
    function automatic void put_entry(ref t_bytes q, input logic [31:0] id,
                                      input logic [7:0] flags, input int bad_word);
        int n_words;
        put_word(q, id, 4);
        q.insert(q.size(), flags);
        n_words = 0;
        if (flags_valid(flags) && flags != rpp_pkg::FLAG_REMOVE) begin
            n_words = ((flags & FL_POS) != 8'd0 ? 3 : 0) + ((flags & FL_ROT) != 8'd0 ? 4 : 0)
                    + ((flags & FL_SCALE) != 8'd0 ? 3 : 0);
        end
        for (int w = 0; w < n_words; w++) begin
            put_word(q, float_word(w == bad_word), 4);
        end
    endfunction

    function automatic logic [7:0] good_flags();
        if ($urandom_range(4) == 0) return rpp_pkg::FLAG_REMOVE;
        return 8'($urandom_range(7, 1));
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_good_packets();
        logic [7:0] flag_set[8] = '{FL_POS, FL_ROT, FL_SCALE, FL_POS | FL_ROT,
                                    FL_POS | FL_SCALE, FL_ROT | FL_SCALE,
                                    FL_POS | FL_ROT | FL_SCALE, rpp_pkg::FLAG_REMOVE};
        t_bytes pkt;
        put_header(pkt, cfg_magic, cfg_version, 16'd8);
        foreach (flag_set[i]) begin
            put_entry(pkt, (i == 0) ? 32'hFFFF_FFFF : 32'(i), flag_set[i], -1);
        end
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd0);
        send_packet(pkt);
    endtask

    task automatic test_short_packets();
        t_bytes pkt;
        pkt.insert(pkt.size(), 8'hFF);
        send_packet(pkt);
        // short wins over a bad magic already seen
        pkt.delete();
        put_header(pkt, ~cfg_magic, cfg_version, 16'd0);
        void'(pkt.pop_back());
        send_packet(pkt);
    endtask

    task automatic test_header_errors();
        t_bytes pkt;
        put_header(pkt, cfg_magic ^ 32'h0000_0100, cfg_version, 16'd1);
        put_entry(pkt, 32'd7, rpp_pkg::FLAG_REMOVE, -1);
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version ^ 16'h8000, 16'd1);
        put_entry(pkt, 32'd7, FL_POS, -1);
        send_packet(pkt);
        // keep the first of two header errors
        pkt.delete();
        put_header(pkt, ~cfg_magic, ~cfg_version, 16'd0);
        send_packet(pkt);
    endtask

    task automatic test_entry_errors();
        logic [7:0] bad_flag_set[4] = '{8'h00, 8'h81, 8'h08, 8'h40};
        t_bytes pkt;
        put_header(pkt, cfg_magic, cfg_version, 16'd2);
        put_entry(pkt, 32'd0, FL_POS, -1);
        put_entry(pkt, 32'd5, rpp_pkg::FLAG_REMOVE, -1);
        send_packet(pkt);
        // zero id ending on the last byte
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_word(pkt, 32'd0, 4);
        send_packet(pkt);
        foreach (bad_flag_set[i]) begin
            pkt.delete();
            put_header(pkt, cfg_magic, cfg_version, 16'd2);
            put_entry(pkt, 32'd3, FL_SCALE, -1);
            put_entry(pkt, 32'd4, bad_flag_set[i], -1);
            put_entry(pkt, 32'd5, rpp_pkg::FLAG_REMOVE, -1);
            send_packet(pkt);
        end
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_entry(pkt, 32'd9, 8'h10, -1);
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd2);
        put_entry(pkt, 32'd11, FL_ROT, 1);
        put_entry(pkt, 32'd12, rpp_pkg::FLAG_REMOVE, -1);
        send_packet(pkt);
        // infinity as the very last word of the packet
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_word(pkt, 32'd13, 4);
        pkt.insert(pkt.size(), FL_SCALE);
        put_word(pkt, 32'h3F80_0000, 4);
        put_word(pkt, 32'hFF7F_FFFF, 4);
        put_word(pkt, 32'h7F80_0000, 4);
        send_packet(pkt);
    endtask

    task automatic test_truncation();
        t_bytes pkt;
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_word(pkt, 32'h0102_0304, 2);
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_entry(pkt, 32'd21, FL_POS, -1);
        repeat (6) void'(pkt.pop_back());
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'hFFFF);
        put_entry(pkt, 32'd22, rpp_pkg::FLAG_REMOVE, -1);
        send_packet(pkt);
    endtask

    task automatic test_trailing();
        t_bytes pkt;
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_entry(pkt, 32'd31, rpp_pkg::FLAG_REMOVE, -1);
        pkt.insert(pkt.size(), 8'h00);
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd0);
        put_entry(pkt, 32'd32, FL_POS, -1);
        send_packet(pkt);
    endtask

    task automatic test_registers();
        t_bytes pkt;
        set_config(32'd0, 16'd0);
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_entry(pkt, 32'd41, FL_ROT, -1);
        send_packet(pkt);
        set_config(32'hFFFF_FFFF, 16'hFFFF);
        pkt.delete();
        put_header(pkt, cfg_magic, cfg_version, 16'd1);
        put_entry(pkt, 32'd42, FL_POS | FL_SCALE, -1);
        send_packet(pkt);
        pkt.delete();
        put_header(pkt, cfg_magic, 16'd1, 16'd0);
        send_packet(pkt);
        set_config(rpp_pkg::MAGIC_RESET, rpp_pkg::VERSION_RESET);
    endtask

    task automatic random_packet(output int n_bytes);
        t_bytes      pkt;
        t_fault      fault;
        int          n_ent;
        int          bad_at;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] count;
        logic [31:0] id;
        logic [7:0]  flags;
        fault = ($urandom_range(99) < 70) ? F_NONE : t_fault'($urandom_range(F_OVERCOUNT, F_CUT));
        if (fault == F_NOISE) begin
            repeat ($urandom_range(16, 1)) pkt.insert(pkt.size(), 8'($urandom));
        end else begin
            n_ent   = (fault inside {F_ZERO_ID, F_BAD_FLAGS, F_NONFINITE}) ?
                      $urandom_range(4, 1) : $urandom_range(4);
            bad_at  = (n_ent > 0) ? $urandom_range(n_ent - 1) : 0;
            magic   = cfg_magic;
            version = cfg_version;
            count   = 16'(n_ent);
            if (fault == F_HEADER) begin
                if ($urandom_range(1) != 0) magic = cfg_magic ^ (32'd1 << $urandom_range(31));
                else version = cfg_version ^ 16'(1 << $urandom_range(15));
            end
            if (fault == F_OVERCOUNT) count = 16'($urandom_range(16'hFFFF, n_ent + 1));
            put_header(pkt, magic, version, count);
            for (int i = 0; i < n_ent; i++) begin
                id = $urandom;
                if (id == 32'd0) id = 32'd1;
                flags = good_flags();
                if (i == bad_at && fault == F_ZERO_ID) id = 32'd0;
                if (i == bad_at && fault == F_BAD_FLAGS) begin
                    do flags = 8'($urandom); while (flags_valid(flags));
                end
                if (i == bad_at && fault == F_NONFINITE) flags = 8'($urandom_range(7, 1));
                put_entry(pkt, id, flags,
                          (i == bad_at && fault == F_NONFINITE) ? $urandom_range(2) : -1);
            end
            case (fault)
                F_CUT:      pkt = pkt[0:$urandom_range(pkt.size() - 2)];
                F_CORRUPT:  pkt[$urandom_range(pkt.size() - 1)] = 8'($urandom);
                F_TRAILING: repeat ($urandom_range(3, 1)) pkt.insert(pkt.size(), 8'($urandom));
                default: ;
            endcase
        end
        send_packet(pkt);
        n_bytes = pkt.size();
    endtask

    task automatic test_random_traffic();
        int sent;
        int n_bytes;
        int budget;
        for (int setup = 0; setup < 4; setup++) begin
            budget = BYTES_PER_SETUP;
            case (setup)
                0: set_config($urandom, 16'($urandom));
                1: begin
                    // long stretch with neither side idling
                    set_config(32'hFFFF_FFFF, 16'hFFFF);
                    src_gap_pct    = 0;
                    sink_stall_pct = 0;
                    budget         = BYTES_NO_IDLE;
                end
                2: begin
                    set_config(32'd0, 16'd0);
                    src_gap_pct    = GAP_PCT;
                    sink_stall_pct = GAP_PCT;
                end
                default: set_config(rpp_pkg::MAGIC_RESET, rpp_pkg::VERSION_RESET);
            endcase
            sent = 0;
            while (sent < budget) begin
                random_packet(n_bytes);
                sent += n_bytes;
            end
        end
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= rpp_pkg::CFG_MAGIC;
        i_cfg_data        <= '0;
        in_chan.valid     <= 1'b0;
        in_chan.data_byte <= 8'd0;
        in_chan.last_byte <= 1'b0;
        cfg_magic   = rpp_pkg::MAGIC_RESET;
        cfg_version = rpp_pkg::VERSION_RESET;
        clear_packet();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_good_packets();
        test_short_packets();
        test_header_errors();
        test_entry_errors();
        test_truncation();
        test_trailing();
        test_registers();
        test_random_traffic();
        settle();

        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
